/* src/k_sorted_stream_sorter_defines.svh */
// Assertion macros shared by the k-sorted stream sorter RTL.
// No dependencies; included by the top level only.
`ifndef K_SORTED_STREAM_SORTER_DEFINES_SVH
`define K_SORTED_STREAM_SORTER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SKS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("k_sorted_stream_sorter: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("k_sorted_stream_sorter: next-cycle check failed");

`endif

/* src/sks_pkg.sv */
// Shared types and constants for the k-sorted stream sorter.
// No dependencies; used by sks_cell, k_sorted_stream_sorter and the bench.
package sks_pkg;

   localparam int ValueWidth = 32;

   typedef logic signed [ValueWidth-1:0] sks_value_type;

   // Operation broadcast to every cell of the window chain at once.
   typedef struct packed {
      logic insert;  // place the incoming value into the ascending chain
      logic pop;     // remove the head and shift every value one cell down
   } sks_op_type;

endpackage

/* src/sks_cell.sv */
// One cell of the sorted window chain: a value register and its valid bit.
// Depends on sks_pkg.
module sks_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  at_head,
   input  sks_pkg::sks_op_type    op,
   input  sks_pkg::sks_value_type new_value,
   input  sks_pkg::sks_value_type prev_value,
   input  logic                  prev_valid,
   input  logic                  prev_le,
   input  sks_pkg::sks_value_type next_value,
   input  logic                  next_valid,
   input  logic                  next_le,
   output sks_pkg::sks_value_type value,
   output logic                  valid,
   output logic                  le
);
   import sks_pkg::*;

   sks_value_type value_ff;
   sks_value_type value_in;
   logic          valid_ff;
   logic          valid_in;

   // A held value stays ahead of the new one when it is not greater, so a new
   // value lands after equal held values.
   assign le    = valid_ff && (value_ff <= new_value);
   assign value = value_ff;
   assign valid = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (op.pop && op.insert) begin
         // The chain is full: this cell sees the shifted chain, where its
         // lower neighbor is its own old value. The head has no lower
         // neighbor left after the pop, so the new value goes there unless
         // the next value precedes it.
         if (next_le) begin
            value_in = next_value;
         end else if (le || at_head) begin
            value_in = new_value;
         end else begin
            value_in = value_ff;
         end
      end else if (op.pop) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (op.insert) begin
         if (!le) begin
            if (prev_le) begin
               value_in = new_value;
            end else begin
               value_in = prev_value;
            end
         end
         valid_in = valid_ff | prev_valid;
      end else begin
         value_in = value_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* src/k_sorted_stream_sorter.sv */
// Top level of the k-sorted stream sorter: a chain of sorting cells plus
// the output register. Depends on sks_pkg, sks_cell and the defines header.
//
// Usage: values of a nearly sorted stream arrive on the req_ channel, one
// transaction per value, with req_end_of_stream marking the last one. The
// sorted values leave on the rsp_ channel; rsp_final_output marks the last
// value of a stream. Each value must lie at most DISPLACEMENT places from
// its sorted position for the output to be sorted.
// The window is a chain of DISPLACEMENT+1 cells kept in ascending order.
// Every cell compares its own value with the incoming one and takes its own,
// the new, or a neighbor's value, so all cells update together on insertion.
// Throughput: one input transaction per cycle while the stream flows. Once
// the window is full, an accepted value also loads the smallest held value
// into the output register in the same cycle.
// At the end of a stream the block stops accepting and drains the window,
// one value per cycle unless the receiver stalls, until all held values
// (at most DISPLACEMENT+1) are out; the next transaction starts a new stream.
// When the receiver stalls, the output register holds its value; input is
// still taken while the window has room, and stalled once it is full.
// Reset empties the window and the output register; no clearing pass is
// needed since only the valid bits reset.
`include "k_sorted_stream_sorter_defines.svh"

module k_sorted_stream_sorter #(
   parameter int DISPLACEMENT = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sks_pkg::sks_value_type req_sample_value,
   input  logic                   req_end_of_stream,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sks_pkg::sks_value_type rsp_sorted_value,
   output logic                   rsp_final_output
);
   import sks_pkg::*;

   localparam int WindowSize = DISPLACEMENT + 1;

   // Per-cell views, with one extra empty position above the last cell so
   // that the chain ends in a neighbor that holds nothing.
   sks_value_type         cell_value [0:WindowSize];
   logic [WindowSize:0]   cell_valid;
   logic [WindowSize:0]   cell_le;

   sks_op_type    op;
   logic          window_full;
   logic          out_free;
   logic          accept;
   logic          drain_pop;
   logic          emit;
   logic          last_held;

   logic          draining_ff;
   logic          draining_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   sks_value_type rsp_value_ff;
   logic          rsp_final_ff;
   logic          rsp_final_in;

   assign cell_value[WindowSize] = '0;
   assign cell_valid[WindowSize] = 1'b0;
   assign cell_le[WindowSize]    = 1'b0;

   // The chain is full when its top cell holds a value, and the head is the
   // only value left when the cell above it is empty.
   assign window_full = cell_valid[WindowSize-1];
   assign last_held   = !cell_valid[1];

   // The output register can take a value when it is empty or being read.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = draining_ff || (window_full && !out_free);
   assign accept    = req_valid && !req_stall;
   assign drain_pop = draining_ff && out_free;
   assign emit      = (accept && window_full) || drain_pop;

   assign op.insert = accept;
   assign op.pop    = emit;

   for (genvar i = 0; i < WindowSize; i++) begin : g_cell
      sks_value_type prev_value;
      logic          prev_valid;
      logic          prev_le;

      if (i == 0) begin : g_head
         // The head has nothing below it: a new value that no held value
         // precedes goes here.
         assign prev_value = req_sample_value;
         assign prev_valid = 1'b1;
         assign prev_le    = 1'b1;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_le    = cell_le[i-1];
      end

      sks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .at_head    (i == 0),
         .op         (op),
         .new_value  (req_sample_value),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_le    (prev_le),
         .next_value (cell_value[i+1]),
         .next_valid (cell_valid[i+1]),
         .next_le    (cell_le[i+1]),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .le         (cell_le[i])
      );
   end

   // A stream ends with a drain of the whole window; the drain stops once the
   // last held value has gone to the output register.
   always_comb begin
      draining_in = draining_ff;
      priority if (accept && req_end_of_stream) begin
         draining_in = 1'b1;
      end else if (drain_pop && last_held) begin
         draining_in = 1'b0;
      end else begin
         draining_in = draining_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Only a drain can hand out the final value; a pop forced by a full
   // window always leaves values behind.
   assign rsp_final_in = drain_pop && last_held;

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         draining_ff  <= draining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= cell_value[0];
         rsp_final_ff <= rsp_final_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_output = rsp_final_ff;

   // The held values always sit in a contiguous run starting at the head.
   `SKS_ASSERT_IMPL(a_window_contiguous, clock, reset, 1'b1,
      $onehot(cell_valid + {{WindowSize{1'b0}}, 1'b1}))
   // A drain never runs on an empty window.
   `SKS_ASSERT_IMPL(a_drain_nonempty, clock, reset, draining_ff, cell_valid[0])
   // The end of a stream always starts a drain.
   `SKS_ASSERT_NEXT(a_end_starts_drain, clock, reset, accept && req_end_of_stream,
      draining_ff)
   // A full window never takes a value without room for the popped head.
   `SKS_ASSERT_IMPL(a_full_pop_has_room, clock, reset, accept && window_full,
      out_free && !draining_ff)

endmodule

/* tb/k_sorted_stream_sorter_checker.sv */
// Checker for the k-sorted stream sorter: a window predictor and a result comparator.
// Depends on sks_pkg. It watches both channels and reports mismatches to the bench top.
module k_sorted_stream_sorter_checker #(
   parameter int DISPLACEMENT = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  sks_pkg::sks_value_type req_sample_value,
   input  logic                   req_end_of_stream,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  sks_pkg::sks_value_type rsp_sorted_value,
   input  logic                   rsp_final_output,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WindowSize = DISPLACEMENT + 1;

   typedef struct packed {
      sks_pkg::sks_value_type value;
      logic                   last;
   } sorted_result_type;

   sorted_result_type      expected_results[$];
   sks_pkg::sks_value_type window_vals[WindowSize];
   int                     held_count = 0;
   int                     mismatches = 0;

   // Removes the head of the window and queues it as the next expected result.
   // During a drain the value that empties the window is the final one.
   function automatic void emit_smallest(input logic draining);
      sorted_result_type item;
      item.value = window_vals[0];
      for (int i = 1; i < held_count; i++) window_vals[i-1] = window_vals[i];
      held_count--;
      item.last = draining && (held_count == 0);
      expected_results.push_back(item);
   endfunction

   // Applies one accepted sample: pop when full, insert after equal values,
   // and drain everything on the end of a stream.
   function automatic void absorb_sample(input sks_pkg::sks_value_type v, input logic last);
      int pos;
      if (held_count >= WindowSize) emit_smallest(1'b0);
      pos = held_count;
      while (pos > 0 && window_vals[pos-1] > v) begin
         window_vals[pos] = window_vals[pos-1];
         pos--;
      end
      window_vals[pos] = v;
      held_count++;
      if (last) begin
         while (held_count > 0) emit_smallest(1'b1);
      end
   endfunction

   // Results are compared before the same edge's sample is absorbed, since a
   // sample can never produce a result in the cycle it is accepted.
   always @(posedge clock) begin : compare_results
      sorted_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("sorted_value: expected none, actual %0d", rsp_sorted_value);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_sorted_value !== want.value) begin
                  $error("sorted_value: expected %0d, actual %0d", want.value, rsp_sorted_value);
                  mismatches++;
               end
               if (rsp_final_output !== want.last) begin
                  $error("final_output: expected %0b, actual %0b", want.last, rsp_final_output);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) absorb_sample(req_sample_value, req_end_of_stream);
      end
      fail_count    <= mismatches;
      pending_count <= expected_results.size();
   end

endmodule

/* tb/tb_k_sorted_stream_sorter.sv */
// Bench top for the k-sorted stream sorter: clock, reset, stimulus and verdict.
// Depends on sks_pkg, k_sorted_stream_sorter and k_sorted_stream_sorter_checker.
module tb_k_sorted_stream_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Displacement = 7;
   localparam int WindowSize   = Displacement + 1;
   localparam int SampleTarget = 410;
   localparam int IdleLimit    = 1000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   sks_pkg::sks_value_type req_sample_value;
   logic                   req_end_of_stream;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   sks_pkg::sks_value_type rsp_sorted_value;
   logic                   rsp_final_output;

   int fail_count;
   int pending_count;
   int samples_sent = 0;
   int idle_cycles  = 0;

   // While this is set neither side idles, which gives the block a long
   // stretch of back-to-back transactions with the window full.
   logic steady = 1'b0;

   k_sorted_stream_sorter #(.DISPLACEMENT(Displacement)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_output (rsp_final_output)
   );

   k_sorted_stream_sorter_checker #(.DISPLACEMENT(Displacement)) checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_output (rsp_final_output),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls with a probability of about 23 percent, except
   // during the steady stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 23);
      end
   end

   // Watchdog: counts cycles in which neither channel completes a
   // transaction. The drain of a full window plus a run of stalls stays
   // far below the limit, so reaching it means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("k_sorted_stream_sorter: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic bit sender_idles();
      return !steady && ($urandom_range(0, 99) < 23);
   endfunction

   // Offers one sample and returns at the edge where the transaction is
   // accepted. Valid is only lowered when an idle gap follows, so a
   // back-to-back transaction never sees valid dropped and raised in one step.
   task automatic send_sample(input sks_pkg::sks_value_type v, input logic last);
      if (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (sender_idles()) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_value  <= v;
      req_end_of_stream <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   // Sends a whole stream; only the last sample carries the end mark.
   task automatic send_stream(input sks_pkg::sks_value_type vals[$]);
      for (int i = 0; i < vals.size(); i++) send_sample(vals[i], i == vals.size() - 1);
   endtask

   // Builds and sends a random stream. A well-formed stream is sorted and
   // then shuffled inside blocks of WindowSize values, which keeps every
   // value within the displacement bound. Otherwise the order stays random
   // and the bound may be violated. A narrow stream draws from a few adjacent
   // values so that equal values are common.
   task automatic random_stream(input int len, input bit ordered, input bit narrow);
      sks_pkg::sks_value_type vals[$];
      sks_pkg::sks_value_type centre;
      sks_pkg::sks_value_type tmp;
      int                     j;
      int                     k;
      int                     blk_end;
      centre = $urandom;
      for (int i = 0; i < len; i++) begin
         if (narrow) vals.push_back(centre + $urandom_range(0, 4));
         else vals.push_back($urandom);
      end
      if (ordered) begin
         for (int i = 1; i < len; i++) begin
            tmp = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > tmp) begin
               vals[j] = vals[j-1];
               j--;
            end
            vals[j] = tmp;
         end
         for (int blk = 0; blk < len; blk += WindowSize) begin
            blk_end = (blk + WindowSize - 1 < len - 1) ? blk + WindowSize - 1 : len - 1;
            for (int i = blk_end; i > blk; i--) begin
               k = $urandom_range(blk, i);
               tmp = vals[i];
               vals[i] = vals[k];
               vals[k] = tmp;
            end
         end
      end
      send_stream(vals);
   endtask

   initial begin
      int pick;
      int len;
      req_valid         <= 1'b0;
      req_sample_value  <= '0;
      req_end_of_stream <= 1'b0;
      reset             <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed streams. A single most negative value, then a single most
      // positive one: each is a one-value stream whose only result is final.
      send_stream('{32'sh8000_0000});
      send_stream('{32'sh7FFF_FFFF});
      // A short stream with equal values, drained before the window fills.
      send_stream('{-32'sd1, 32'sd0, -32'sd1});
      // Nine values: the ninth pops the minimum of a full window and then the
      // end mark drains eight more, the most results one transaction causes.
      send_stream('{32'sd3, 32'sh8000_0000, 32'sd1, 32'sd0, 32'sh7FFF_FFFF,
                    -32'sd1, 32'sd2, 32'sd5, 32'sd4});
      // A descending stream of five values stays within the displacement
      // bound, so the window still gives it back fully sorted.
      send_stream('{32'sh7FFF_FFFF, 32'sd100, 32'sd0, -32'sd100, 32'sh8000_0000});

      // Random streams. Most obey the bound so the window runs full for long
      // stretches; the rest are out of order.
      while (samples_sent < SampleTarget) begin
         steady <= (samples_sent >= 180) && (samples_sent < 260);
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            random_stream(len, 1'b1, $urandom_range(0, 3) == 0);
         end else begin
            random_stream($urandom_range(1, 20), 1'b0, $urandom_range(0, 3) == 0);
         end
      end
      steady <= 1'b0;
      req_valid         <= 1'b0;
      req_end_of_stream <= 1'b0;
      @(posedge clock);

      // Every stream ends with a drain, so once nothing is pending the block
      // should be idle; waiting on after that catches any stray result.
      while (pending_count != 0) @(posedge clock);
      repeat (WindowSize + 4) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("k_sorted_stream_sorter: match");
      end else begin
         $display("k_sorted_stream_sorter: mismatch");
      end
      $finish;
   end

endmodule
